### rtl/cpualu_pkg.sv
// Shared types and constants for the 8-bit accumulator ALU.
package cpualu_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_ADC = 3'd1,
    CMD_AND = 3'd2,
    CMD_CP  = 3'd3,
    CMD_DAA = 3'd4,
    CMD_CPL = 3'd5,
    CMD_CCF = 3'd6,
    CMD_INC = 3'd7
  } cmd_t;

  // flag nibble: bit3 Z, bit2 N, bit1 H, bit0 C
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // first field in the highest bits
  typedef struct packed {
    flags_t     flags_in;
    logic [7:0] operand;
    logic [7:0] accumulator;
    cmd_t       command;
  } in_item_t;

  typedef struct packed {
    flags_t     flags_out;
    logic [7:0] value_out;
  } res_item_t;

  localparam int unsigned InWidth  = $bits(in_item_t);
  localparam int unsigned ResWidth = $bits(res_item_t);
  localparam int unsigned InBytes  = (InWidth + 7) / 8;
  localparam int unsigned ResBytes = (ResWidth + 7) / 8;

  localparam logic [7:0] DaaLimit  = 8'h99;
  localparam logic [7:0] DaaHigh   = 8'h60;
  localparam logic [7:0] DaaLow    = 8'h06;
  localparam logic [3:0] NibbleMax = 4'h9;
  localparam logic [3:0] NibbleAll = 4'hF;

endpackage

### rtl/cpualu_core.sv
// Combinational datapath: value and flags for one ALU word.
module cpualu_core import cpualu_pkg::*; (
  input  in_item_t  item,
  output res_item_t res
);

  logic [8:0] sum;
  logic [4:0] nib_sum;
  logic       cin;
  logic       c60;
  logic       c06;
  logic [7:0] corr;
  logic [7:0] inc_val;
  logic [7:0] value;
  flags_t     f;
  flags_t     nf;

  assign f   = item.flags_in;
  assign cin = (item.command == CMD_ADC) ? f.c : 1'b0;

  assign sum     = {1'b0, item.accumulator} + {1'b0, item.operand} + {8'd0, cin};
  assign nib_sum = {1'b0, item.accumulator[3:0]} + {1'b0, item.operand[3:0]} + {4'd0, cin};
  assign inc_val = item.operand + 8'd1;

  // decimal adjust: correction picked from the incoming H, C and N and the accumulator digits
  assign c60  = f.n ? f.c : (f.c || (item.accumulator > DaaLimit));
  assign c06  = f.n ? f.h : (f.h || (item.accumulator[3:0] > NibbleMax));
  assign corr = (c60 ? DaaHigh : 8'h00) | (c06 ? DaaLow : 8'h00);

  always_comb begin
    value = item.accumulator;
    nf    = f;
    case (item.command)
      CMD_ADD, CMD_ADC: begin
        value = sum[7:0];
        nf    = '{z: (sum[7:0] == 8'd0), n: 1'b0, h: nib_sum[4], c: sum[8]};
      end
      CMD_AND: begin
        value = item.accumulator & item.operand;
        nf    = '{z: (value == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      CMD_CP: begin
        nf = '{z: (item.accumulator == item.operand), n: 1'b1,
               h: (item.accumulator[3:0] < item.operand[3:0]),
               c: (item.accumulator < item.operand)};
      end
      CMD_DAA: begin
        value = f.n ? (item.accumulator - corr) : (item.accumulator + corr);
        nf    = '{z: (value == 8'd0), n: f.n, h: 1'b0, c: f.c | (c60 & ~f.n)};
      end
      CMD_CPL: begin
        value = ~item.accumulator;
        nf    = '{z: f.z, n: 1'b1, h: 1'b1, c: f.c};
      end
      CMD_CCF: begin
        nf = '{z: f.z, n: 1'b0, h: 1'b0, c: ~f.c};
      end
      CMD_INC: begin
        value = inc_val;
        nf    = '{z: (inc_val == 8'd0), n: 1'b0,
                  h: (item.operand[3:0] == NibbleAll), c: f.c};
      end
      default: begin
        value = item.accumulator;
        nf    = f;
      end
    endcase
  end

  assign res = '{flags_out: nf, value_out: value};

endmodule

### rtl/cpu_alu_with_flags_top.sv
// An accepted input word passes the input register, then the result register, to the master side.
// Throughput: one word per cycle while the master side takes results; input register, ALU logic, result register.
// s_tready drops only when both registers are full and the result is not taken.
// Reset (rst, synchronous, active high) empties both registers; nothing else is kept.
// Top level of the 8-bit accumulator ALU with flags.
module cpu_alu_with_flags_top import cpualu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // command[2:0], accumulator[10:3], operand[18:11], flags_in[22:19], zero pad
  input  logic [InBytes*8-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // value_out[7:0], flags_out[11:8], zero pad
  output logic [ResBytes*8-1:0] m_tdata
);

  logic      in_valid;
  in_item_t  in_reg;
  res_item_t res_next;
  res_item_t res_reg;
  logic      out_adv;

  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg <= in_item_t'(s_tdata[InWidth-1:0]);
    end
  end

  cpualu_core u_core (
    .item (in_reg),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      res_reg <= res_next;
    end
  end

  assign m_tdata = {{(ResBytes*8-ResWidth){1'b0}}, res_reg};

endmodule

### rtl/cpualu_checker.sv
// Port-level assertions for the ALU top level, bound into it.
module cpualu_checker import cpualu_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [ResBytes*8-1:0] m_tdata
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // the pipe never back-pressures while the sink takes words
  a_no_block: assert property (@(posedge clk) m_tready |-> s_tready)
    else $error("input stalled while output ready");

  // an accepted word passes from the input register into the result register when the sink is ready
  a_latency: assert property (@(posedge clk)
      (s_tvalid && s_tready && !rst) ##1 (m_tready && !rst) |=> m_tvalid)
    else $error("result word missing after two cycles");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

endmodule

bind cpu_alu_with_flags_top cpualu_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
